FILE: design/sdi_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds character codes, channel widths and the digit-count helper.
// No dependencies.
`default_nettype none

package sdi_pkg;

  localparam int VALUE_BITS         = 64;
  localparam int CHAR_BITS          = 6;
  localparam int VALUE_WIDTH_DEFAULT = 64;

  // Bits consumed by the double-dabble unit in one cycle.
  localparam int DABBLE_BITS = 4;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;

  localparam logic [3:0] DIGIT_MAX     = 4'd9;
  localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [3:0] DIGIT_ADJ     = 4'd3;

  // log10(2) as 1233 / 4096, exact enough for widths up to 64.
  localparam int LOG10_2_NUM = 1233;
  localparam int LOG10_2_DEN = 4096;

  // Decimal digits needed for magnitudes up to 2^(width-1).
  function automatic int num_digits(input int width);
    return ((width - 1) * LOG10_2_NUM) / LOG10_2_DEN + 1;
  endfunction

endpackage : sdi_pkg

`default_nettype wire

FILE: design/sdi_if.sv
// Channel interfaces of the converter: integer in, characters out.
// Depends on sdi_pkg for the payload widths.
`default_nettype none

interface sdi_value_if;
  import sdi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : sdi_value_if

interface sdi_char_if;
  import sdi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] text_char;
  logic                 last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface : sdi_char_if

`default_nettype wire

FILE: design/sdi_dabble.sv
// Combinational double-dabble step: folds DABBLE_BITS magnitude bits into the BCD word.
// Depends on sdi_pkg for the step size and the adjust constants.
`default_nettype none

module sdi_dabble #(
  parameter int NUM_DIGITS = 19
) (
  input  wire logic [4*NUM_DIGITS-1:0]          bcd_in,
  input  wire logic [sdi_pkg::DABBLE_BITS-1:0]  bits_in,
  output logic      [4*NUM_DIGITS-1:0]          bcd_out
);
  import sdi_pkg::*;

  always_comb begin
    logic [4*NUM_DIGITS-1:0] work;
    work = bcd_in;
    // Per bit, MSB first: add 3 to every digit of 5 or more, then shift in.
    for (int b = DABBLE_BITS - 1; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work[4*d +: 4] >= DIGIT_ADJ_MIN) begin
          work[4*d +: 4] = work[4*d +: 4] + DIGIT_ADJ;
        end
      end
      work = {work[4*NUM_DIGITS-2:0], bits_in[b]};
    end
    bcd_out = work;
  end

endmodule : sdi_dabble

`default_nettype wire

FILE: design/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter, top level and sequencer.
// Uses sdi_pkg, the channel interfaces in sdi_if and the sdi_dabble unit.
//
// Usage: an integer arrives on the number channel (valid/ready); only the low
// VALUE_WIDTH bits count, bit VALUE_WIDTH-1 is the sign. Its decimal text
// leaves on the text channel, one character per transaction, most significant
// first: a '-' for negative values, then the digits without leading zeros
// ('0' alone for zero). last_char marks the final digit. The most negative
// value prints as '-' and the digits of 2^(VALUE_WIDTH-1).
//
// Timing: one integer at a time. After acceptance the double-dabble unit folds
// in the magnitude 4 bits a cycle, the S_COUNT state finds the leading digit,
// then the characters go out one per cycle through the output register while
// the receiver takes them. ready returns as soon as the last character is
// loaded, so the next integer is taken while that character still waits. A
// receiver stall holds the character and the sequencer. Reset (rst, synchronous)
// empties the output register and returns to idle.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sdi_pkg::VALUE_WIDTH_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst,
  sdi_value_if.sink    number,
  sdi_char_if.source   text
);
  import sdi_pkg::*;

  localparam int NumDigits = num_digits(VALUE_WIDTH);
  localparam int Steps     = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
  localparam int PadWidth  = Steps * DABBLE_BITS;
  localparam int StepW     = $clog2(Steps);
  localparam int IdxW      = $clog2(NumDigits);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_COUNT,
    S_EMIT
  } state_t;

  state_t                  state;
  logic [PadWidth-1:0]     mag;
  logic [4*NumDigits-1:0]  bcd;
  logic [4*NumDigits-1:0]  bcd_next;
  logic [StepW-1:0]        step;
  logic [IdxW-1:0]         idx;
  logic [IdxW-1:0]         top_digit;
  logic                    neg;
  logic                    sign_pending;
  logic                    out_valid;
  logic [CHAR_BITS-1:0]    out_char;
  logic                    out_last;

  logic [VALUE_WIDTH-1:0]  in_value;
  logic [VALUE_WIDTH-1:0]  in_mag;
  logic                    in_neg;
  logic                    load_out;

  assign in_value = number.value[VALUE_WIDTH-1:0];
  assign in_neg   = in_value[VALUE_WIDTH-1];
  // Two's complement negate; the most negative value maps onto itself as unsigned.
  assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

  assign number.ready   = (state == S_IDLE);
  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last_char = out_last;

  assign load_out = !out_valid || text.ready;

  sdi_dabble #(
    .NUM_DIGITS (NumDigits)
  ) u_dabble (
    .bcd_in  (bcd),
    .bits_in (mag[PadWidth-1 -: DABBLE_BITS]),
    .bcd_out (bcd_next)
  );

  // Highest nonzero digit; zero when every digit is zero.
  always_comb begin
    top_digit = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        top_digit = IdxW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken character; S_EMIT reloads or holds the register itself.
      if (state != S_EMIT && text.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (number.valid) begin
            mag          <= PadWidth'(in_mag);
            neg          <= in_neg;
            sign_pending <= in_neg;
            bcd          <= '0;
            step         <= StepW'(Steps - 1);
            state        <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          bcd  <= bcd_next;
          mag  <= mag << DABBLE_BITS;
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          idx   <= top_digit;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            out_valid <= 1'b1;
            if (sign_pending) begin
              out_char     <= CHAR_MINUS;
              out_last     <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              out_char <= CHAR_ZERO + {2'b00, bcd[4*idx +: 4]};
              out_last <= (idx == '0);
              idx      <= idx - 1'b1;
              if (idx == '0) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_starts_convert: assert property (@(posedge clk) disable iff (rst)
    (number.valid && number.ready) |=> (state == S_CONVERT))
    else $error("accepted integer did not start conversion");

  a_char_is_sign_or_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char == CHAR_MINUS ||
                   (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + {2'b00, DIGIT_MAX})))
    else $error("output character is neither minus nor digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_sign_only_if_negative: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && sign_pending) |-> neg)
    else $error("sign pending for a non-negative value");
`endif

endmodule : signed_int_to_decimal_ascii

`default_nettype wire
